// ----- rtl/core/bmd_pkg.sv -----
`default_nettype none
package bmd_pkg;

  localparam int COLOR_W    = 32;
  localparam int DIM_W      = 7;
  localparam int SCALE_W    = 11;
  localparam int SPAN_W     = 3;
  localparam int COORD_W    = 9;
  localparam int TGT_W      = 6;
  localparam int PIX_IDX_W  = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  localparam logic [COLOR_W-1:0] NO_COLOR  = 32'hFFFF_FFFF;
  localparam logic [SCALE_W-1:0] SCALE_MIN = 11'd257;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 11'd1024;
  localparam logic [SCALE_W:0]   SCALE_RND = 12'd255;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 4'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_SELECT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [SCALE_W-1:0] sx;
    logic [SCALE_W-1:0] sy;
    logic [SPAN_W-1:0]  spanx;
    logic [SPAN_W-1:0]  spany;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic sample;
    logic select;
  } tally_ctl_t;

  typedef struct packed {
    logic               done;
    logic [COLOR_W-1:0] best;
  } tally_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/bmd_ram.sv -----
`default_nettype none
module bmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/bmd_cfg.sv -----
`default_nettype none
module bmd_cfg #(
  parameter int MAX_DIM = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bmd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bmd_pkg::cfg_t                          cfg
);

  localparam int DW        = bmd_pkg::DIM_W;
  localparam int SW        = bmd_pkg::SCALE_W;
  localparam int DIM_CAP_I = (MAX_DIM > 127) ? 127 : MAX_DIM;
  localparam logic [DW-1:0] DIM_CAP = DW'(DIM_CAP_I);

  logic [DW-1:0] src_width;
  logic [DW-1:0] src_height;
  logic [SW-1:0] scale_x;
  logic [SW-1:0] scale_y;
  logic [SW:0]   sum_x;
  logic [SW:0]   sum_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 7'd64;
      src_height <= 7'd64;
      scale_x    <= 11'd512;
      scale_y    <= 11'd512;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bmd_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data[DW-1:0];
        bmd_pkg::REG_SRC_HEIGHT: src_height <= cfg_data[DW-1:0];
        bmd_pkg::REG_SCALE_X:    scale_x    <= cfg_data[SW-1:0];
        bmd_pkg::REG_SCALE_Y:    scale_y    <= cfg_data[SW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.w  = (src_width  > DIM_CAP) ? DIM_CAP : src_width;
    cfg.h  = (src_height > DIM_CAP) ? DIM_CAP : src_height;
    cfg.sx = (scale_x < bmd_pkg::SCALE_MIN) ? bmd_pkg::SCALE_MIN :
             (scale_x > bmd_pkg::SCALE_MAX) ? bmd_pkg::SCALE_MAX : scale_x;
    cfg.sy = (scale_y < bmd_pkg::SCALE_MIN) ? bmd_pkg::SCALE_MIN :
             (scale_y > bmd_pkg::SCALE_MAX) ? bmd_pkg::SCALE_MAX : scale_y;
    sum_x  = {1'b0, cfg.sx} + bmd_pkg::SCALE_RND;
    sum_y  = {1'b0, cfg.sy} + bmd_pkg::SCALE_RND;
    cfg.spanx = sum_x[SW-1:8];
    cfg.spany = sum_y[SW-1:8];
  end

endmodule
`default_nettype wire

// ----- rtl/core/bmd_scan.sv -----
`default_nettype none
module bmd_scan #(
  parameter int MAX_DIM   = 64,
  parameter int MAX_BLOCK = 16,
  localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [bmd_pkg::TGT_W-1:0]     target_x,
  input  wire logic [bmd_pkg::TGT_W-1:0]     target_y,
  input  wire bmd_pkg::cfg_t                 cfg,
  input  wire bmd_pkg::tally_stat_t          stat,
  input  wire logic                          out_free,
  output logic                               busy,
  output logic                               out_load,
  output logic                               rd_en,
  output logic [AW-1:0]                      rd_addr,
  output bmd_pkg::tally_ctl_t                ctl
);

  localparam int CW    = bmd_pkg::COORD_W;
  localparam int SPW   = bmd_pkg::SPAN_W;
  localparam int SMP_W = $clog2(MAX_BLOCK + 1);
  localparam int PW    = 17;

  bmd_pkg::state_t state, state_next;

  logic [CW-1:0]    x0, x0_next;
  logic [CW-1:0]    y0, y0_next;
  logic [SPW-1:0]   dx, dx_next;
  logic [SPW-1:0]   dy, dy_next;
  logic [SMP_W-1:0] samples, samples_next;
  logic             sample_q;

  logic [PW-1:0] prod_x;
  logic [PW-1:0] prod_y;
  logic [CW-1:0] x;
  logic [CW-1:0] y;
  logic [CW-1:0] w_ext;
  logic [CW-1:0] h_ext;
  logic [PW-1:0] lin;
  logic          scan_end;
  logic          col_last;
  logic          issue;

  always_comb begin
    prod_x   = PW'(target_x) * PW'(cfg.sx);
    prod_y   = PW'(target_y) * PW'(cfg.sy);
    x0_next  = prod_x[PW-1:8];
    y0_next  = prod_y[PW-1:8];
    x        = x0 + CW'(dx);
    y        = y0 + CW'(dy);
    w_ext    = CW'(cfg.w);
    h_ext    = CW'(cfg.h);
    scan_end = (dx == cfg.spanx) || (x >= w_ext) || (y0 >= h_ext) ||
               (samples == SMP_W'(MAX_BLOCK));
    col_last = ((dy + SPW'(1)) == cfg.spany) || ((y + CW'(1)) >= h_ext);
    lin      = PW'(y) * PW'(cfg.w) + PW'(x);
  end

  always_comb begin
    state_next = state;
    case (state)
      bmd_pkg::S_IDLE:   if (start) state_next = bmd_pkg::S_SCAN;
      bmd_pkg::S_SCAN:   if (scan_end) state_next = bmd_pkg::S_DRAIN;
      bmd_pkg::S_DRAIN:  state_next = bmd_pkg::S_SELECT;
      bmd_pkg::S_SELECT: if (stat.done) state_next = bmd_pkg::S_OUT;
      bmd_pkg::S_OUT:    if (out_free) state_next = bmd_pkg::S_IDLE;
      default:           state_next = bmd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != bmd_pkg::S_IDLE);
    issue      = (state == bmd_pkg::S_SCAN) && !scan_end;
    rd_en      = issue;
    rd_addr    = AW'(lin);
    out_load   = (state == bmd_pkg::S_OUT) && out_free;
    ctl.clear  = (state == bmd_pkg::S_IDLE) && start;
    ctl.sample = sample_q;
    ctl.select = (state == bmd_pkg::S_SELECT);
  end

  always_comb begin
    dx_next      = dx;
    dy_next      = dy;
    samples_next = samples;
    if (ctl.clear) begin
      dx_next      = '0;
      dy_next      = '0;
      samples_next = '0;
    end else if (issue) begin
      samples_next = samples + SMP_W'(1);
      if (col_last) begin
        dx_next = dx + SPW'(1);
        dy_next = '0;
      end else begin
        dy_next = dy + SPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bmd_pkg::S_IDLE;
      sample_q <= 1'b0;
      dx       <= '0;
      dy       <= '0;
      samples  <= '0;
    end else begin
      state    <= state_next;
      sample_q <= issue;
      dx       <= dx_next;
      dy       <= dy_next;
      samples  <= samples_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      x0 <= x0_next;
      y0 <= y0_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/bmd_tally.sv -----
`default_nettype none
module bmd_tally #(
  parameter int MAX_BLOCK = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire bmd_pkg::tally_ctl_t            ctl,
  input  wire logic [bmd_pkg::COLOR_W-1:0]    color_in,
  output bmd_pkg::tally_stat_t                stat
);

  localparam int CLW   = bmd_pkg::COLOR_W;
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);

  logic [CLW-1:0]   colors [MAX_BLOCK];
  logic [CNT_W-1:0] counts [MAX_BLOCK];
  logic [MAX_BLOCK-1:0] used;
  logic [MAX_BLOCK-1:0] hit;
  logic             any_hit;
  logic [CNT_W-1:0] distinct;
  logic [CNT_W-1:0] best_cnt;
  logic [CLW-1:0]   best;
  logic             take_best;

  always_comb begin
    for (int k = 0; k < MAX_BLOCK; k++) begin
      hit[k] = used[k] && (colors[k] == color_in);
    end
    any_hit   = |hit;
    take_best = used[0] && (counts[0] > best_cnt);
    stat.done = !used[0];
    stat.best = best;
  end

  // entries stay packed from index 0, selection shifts them toward index 0
  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      distinct <= '0;
      best_cnt <= '0;
    end else if (ctl.clear) begin
      used     <= '0;
      distinct <= '0;
      best_cnt <= '0;
    end else if (ctl.sample) begin
      if (!any_hit) begin
        distinct <= distinct + CNT_W'(1);
        for (int k = 0; k < MAX_BLOCK; k++) begin
          if (distinct == CNT_W'(k)) begin
            used[k] <= 1'b1;
          end
        end
      end
    end else if (ctl.select) begin
      if (take_best) begin
        best_cnt <= counts[0];
      end
      for (int k = 0; k < MAX_BLOCK - 1; k++) begin
        used[k] <= used[k+1];
      end
      used[MAX_BLOCK-1] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best <= bmd_pkg::NO_COLOR;
    end else if (ctl.sample) begin
      for (int k = 0; k < MAX_BLOCK; k++) begin
        if (hit[k]) begin
          counts[k] <= counts[k] + CNT_W'(1);
        end else if (!any_hit && (distinct == CNT_W'(k))) begin
          colors[k] <= color_in;
          counts[k] <= CNT_W'(1);
        end
      end
    end else if (ctl.select) begin
      if (take_best) begin
        best <= colors[0];
      end
      for (int k = 0; k < MAX_BLOCK - 1; k++) begin
        colors[k] <= colors[k+1];
        counts[k] <= counts[k+1];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/block_mode_downscale.sv -----
// compute transaction: from accept to result, the block scans n samples (at most
// MAX_BLOCK, one source memory read each), drains, then takes one selection step
// per distinct color d before loading the result; one compute at a time
// write transaction: one per cycle while in_stall is low (no compute busy), no result
// reset clears control and loads the config defaults; image memory is undefined
// until written
`default_nettype none
module block_mode_downscale #(
  parameter int MAX_DIM   = 64,
  parameter int MAX_BLOCK = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bmd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              command,
  input  wire logic [bmd_pkg::PIX_IDX_W-1:0]     pixel_index,
  input  wire logic [bmd_pkg::COLOR_W-1:0]       pixel_color,
  input  wire logic [bmd_pkg::TGT_W-1:0]         target_x,
  input  wire logic [bmd_pkg::TGT_W-1:0]         target_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [bmd_pkg::COLOR_W-1:0]       target_color
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CLW   = bmd_pkg::COLOR_W;

  bmd_pkg::cfg_t        cfg;
  bmd_pkg::tally_ctl_t  ctl;
  bmd_pkg::tally_stat_t stat;

  logic           busy;
  logic           in_take;
  logic           start;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [CLW-1:0] rd_data;
  logic           out_free;
  logic           out_load;

  assign in_stall = busy;
  assign in_take  = in_valid && !in_stall;
  assign start    = in_take && (command == bmd_pkg::CMD_COMPUTE);
  assign wr_en    = in_take && (command == bmd_pkg::CMD_WRITE) &&
                    (int'(pixel_index) < DEPTH);
  assign wr_addr  = AW'(pixel_index);
  assign out_free = !out_valid || !out_stall;

  bmd_cfg #(
    .MAX_DIM(MAX_DIM)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  bmd_ram #(
    .WIDTH(CLW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(pixel_color),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  bmd_scan #(
    .MAX_DIM  (MAX_DIM),
    .MAX_BLOCK(MAX_BLOCK)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .target_x(target_x),
    .target_y(target_y),
    .cfg     (cfg),
    .stat    (stat),
    .out_free(out_free),
    .busy    (busy),
    .out_load(out_load),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .ctl     (ctl)
  );

  bmd_tally #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_tally (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .color_in(rd_data),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      target_color <= stat.best;
    end
  end

endmodule
`default_nettype wire
